>>> rtl/core/lpws_pkg.sv
// Shared types and constants of the LED pulse-width serializer.
package lpws_pkg;

	localparam int ZONE_COUNT  = 4;
	localparam int ZONE_W      = 2;
	localparam int LINE_W      = 4;
	localparam int BYTE_W      = 8;
	localparam int BIT_CNT_W   = 3;
	localparam int PULSE_W     = 10;
	localparam int TICK_W      = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;

	localparam logic [PULSE_W-1:0] ZERO_HIGH_RST = 10'd50;
	localparam logic [PULSE_W-1:0] ZERO_LOW_RST  = 10'd106;
	localparam logic [PULSE_W-1:0] ONE_HIGH_RST  = 10'd100;
	localparam logic [PULSE_W-1:0] ONE_LOW_RST   = 10'd56;
	localparam logic [TICK_W-1:0]  LATCH_RST     = 16'd7500;

	localparam logic [BIT_CNT_W-1:0] LAST_BIT_IDX = 3'd7;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HIGH,
		PH_LOW,
		PH_LATCH
	} phase_t;

	typedef struct packed {
		logic [PULSE_W-1:0] zero_high;
		logic [PULSE_W-1:0] zero_low;
		logic [PULSE_W-1:0] one_high;
		logic [PULSE_W-1:0] one_low;
		logic [TICK_W-1:0]  latch;
	} timing_cfg_t;

	typedef struct packed {
		logic              offer_byte;
		logic [BYTE_W-1:0] color_byte;
		logic [ZONE_W-1:0] zone_select;
		logic              frame_end;
	} in_item_t;

	typedef struct packed {
		logic [LINE_W-1:0] line_levels;
		logic              byte_taken;
		logic              busy_res;
		logic              frame_done;
	} out_item_t;

endpackage

>>> rtl/core/lpws_if.sv
// Valid/ready channel interfaces for tick items and result items.
interface lpws_in_if;
	logic                       valid;
	logic                       ready;
	logic                       offer_byte;
	logic [lpws_pkg::BYTE_W-1:0] color_byte;
	logic [lpws_pkg::ZONE_W-1:0] zone_select;
	logic                       frame_end;

	modport source (output valid, offer_byte, color_byte, zone_select, frame_end,
		input ready);
	modport sink (input valid, offer_byte, color_byte, zone_select, frame_end,
		output ready);
endinterface

interface lpws_out_if;
	logic                       valid;
	logic                       ready;
	logic [lpws_pkg::LINE_W-1:0] line_levels;
	logic                       byte_taken;
	logic                       busy_res;
	logic                       frame_done;

	modport source (output valid, line_levels, byte_taken, busy_res, frame_done,
		input ready);
	modport sink (input valid, line_levels, byte_taken, busy_res, frame_done,
		output ready);
endinterface

>>> rtl/core/led_pulse_width_serializer_unit.sv
// LED pulse-width serializer: ingress register, bit-timing engine, result register.
//
// Usage: every transaction on in_ch is one clock tick of the pulse timer. It may
// offer a color byte with a zone number and a frame-end mark. For each input
// transaction exactly one result transaction appears on out_ch, carrying the
// zone line levels for that tick, whether the offered byte was taken, the busy
// flag and the one-tick frame-done pulse.
// Each result passes through the ingress register and then the result register
// before it is presented. Throughput is one transaction per cycle while out_ch.ready
// stays high; the state machine advances once per tick item.
// Timing registers are written through cfg_we/cfg_index/cfg_data and should be
// changed only while no tick is in flight.
// Reset clears the state machine to idle, empties both registers and restores
// the default bit and latch timings.
// When the receiver holds out_ch.ready low, the result register holds its
// transaction, the ingress register keeps the next tick and in_ch.ready drops
// once both are occupied; no tick is lost or processed twice.
module led_pulse_width_serializer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	lpws_in_if.sink                          in_ch,
	lpws_out_if.source                       out_ch,
	input  logic                             cfg_we,
	input  logic [lpws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpws_pkg::CFG_DATA_W-1:0] cfg_data
);

	lpws_pkg::timing_cfg_t timing;
	lpws_pkg::in_item_t    item_s1;
	logic                  valid_s1;
	lpws_pkg::out_item_t   result;
	lpws_pkg::out_item_t   out_q;
	logic                  out_valid_q;
	logic                  advance;

	lpws_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.timing    (timing)
	);

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.offer_byte  <= in_ch.offer_byte;
			item_s1.color_byte  <= in_ch.color_byte;
			item_s1.zone_select <= in_ch.zone_select;
			item_s1.frame_end   <= in_ch.frame_end;
		end
	end

	lpws_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.timing (timing),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.line_levels = out_q.line_levels;
	assign out_ch.byte_taken  = out_q.byte_taken;
	assign out_ch.busy_res    = out_q.busy_res;
	assign out_ch.frame_done  = out_q.frame_done;

endmodule

>>> rtl/core/lpws_cfg.sv
// Timing configuration registers of the LED pulse-width serializer.
module lpws_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lpws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpws_pkg::CFG_DATA_W-1:0] cfg_data,
	output lpws_pkg::timing_cfg_t            timing
);

	lpws_pkg::timing_cfg_t timing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.zero_high <= lpws_pkg::ZERO_HIGH_RST;
			timing_q.zero_low  <= lpws_pkg::ZERO_LOW_RST;
			timing_q.one_high  <= lpws_pkg::ONE_HIGH_RST;
			timing_q.one_low   <= lpws_pkg::ONE_LOW_RST;
			timing_q.latch     <= lpws_pkg::LATCH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lpws_pkg::REG_ZERO_HIGH: timing_q.zero_high <= cfg_data[lpws_pkg::PULSE_W-1:0];
				lpws_pkg::REG_ZERO_LOW:  timing_q.zero_low  <= cfg_data[lpws_pkg::PULSE_W-1:0];
				lpws_pkg::REG_ONE_HIGH:  timing_q.one_high  <= cfg_data[lpws_pkg::PULSE_W-1:0];
				lpws_pkg::REG_ONE_LOW:   timing_q.one_low   <= cfg_data[lpws_pkg::PULSE_W-1:0];
				lpws_pkg::REG_LATCH:     timing_q.latch     <= cfg_data[lpws_pkg::TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign timing = timing_q;

endmodule

>>> rtl/core/lpws_engine.sv
// Bit-timing state machine: consumes one tick item per step and forms its result.
module lpws_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  lpws_pkg::in_item_t    item,
	input  lpws_pkg::timing_cfg_t timing,
	output lpws_pkg::out_item_t   result
);

	lpws_pkg::phase_t                   phase_q, phase_d;
	logic [lpws_pkg::BYTE_W-1:0]        shift_q, shift_d;
	logic [lpws_pkg::BIT_CNT_W-1:0]     bits_q, bits_d;
	logic [lpws_pkg::TICK_W-1:0]        tick_q, tick_d;
	logic                               last_q, last_d;
	logic [lpws_pkg::ZONE_W-1:0]        zone_q, zone_d;

	logic                               ends;
	logic                               take;
	logic [lpws_pkg::BYTE_W-1:0]        shifted;
	logic [lpws_pkg::PULSE_W-1:0]       take_high;
	logic [lpws_pkg::PULSE_W-1:0]       next_high;
	logic [lpws_pkg::PULSE_W-1:0]       low_len;

	assign ends    = (tick_q <= lpws_pkg::TICK_W'(1));
	assign shifted = {shift_q[lpws_pkg::BYTE_W-2:0], 1'b0};

	assign take_high = item.color_byte[lpws_pkg::BYTE_W-1] ? timing.one_high : timing.zero_high;
	assign next_high = shifted[lpws_pkg::BYTE_W-1] ? timing.one_high : timing.zero_high;
	assign low_len   = shift_q[lpws_pkg::BYTE_W-1] ? timing.one_low : timing.zero_low;

	// A byte is taken when idle, or at the end of the last low phase of a byte
	// that did not close its frame.
	assign take = item.offer_byte &&
		((phase_q == lpws_pkg::PH_IDLE) ||
		 ((phase_q == lpws_pkg::PH_LOW) && ends && (bits_q == '0) && !last_q));

	always_comb begin
		phase_d = phase_q;
		shift_d = shift_q;
		bits_d  = bits_q;
		tick_d  = tick_q;
		last_d  = last_q;
		zone_d  = zone_q;
		if (take) begin
			phase_d = lpws_pkg::PH_HIGH;
			shift_d = item.color_byte;
			bits_d  = lpws_pkg::LAST_BIT_IDX;
			tick_d  = lpws_pkg::TICK_W'(take_high);
			last_d  = item.frame_end;
			zone_d  = item.zone_select;
		end else begin
			case (phase_q)
				lpws_pkg::PH_HIGH: begin
					if (ends) begin
						phase_d = lpws_pkg::PH_LOW;
						tick_d  = lpws_pkg::TICK_W'(low_len);
					end else begin
						tick_d = tick_q - lpws_pkg::TICK_W'(1);
					end
				end
				lpws_pkg::PH_LOW: begin
					if (!ends) begin
						tick_d = tick_q - lpws_pkg::TICK_W'(1);
					end else if (bits_q != '0) begin
						bits_d  = bits_q - lpws_pkg::BIT_CNT_W'(1);
						shift_d = shifted;
						phase_d = lpws_pkg::PH_HIGH;
						tick_d  = lpws_pkg::TICK_W'(next_high);
					end else if (last_q) begin
						last_d  = 1'b0;
						phase_d = lpws_pkg::PH_LATCH;
						tick_d  = timing.latch;
					end else begin
						phase_d = lpws_pkg::PH_IDLE;
						tick_d  = '0;
					end
				end
				lpws_pkg::PH_LATCH: begin
					if (ends) begin
						phase_d = lpws_pkg::PH_IDLE;
						tick_d  = '0;
					end else begin
						tick_d = tick_q - lpws_pkg::TICK_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Line levels and busy show the state at the start of the tick.
	always_comb begin
		result.line_levels = '0;
		if ((phase_q == lpws_pkg::PH_HIGH) && (32'(zone_q) < lpws_pkg::ZONE_COUNT)) begin
			result.line_levels = lpws_pkg::LINE_W'(1) << zone_q;
		end
		result.byte_taken = take;
		result.busy_res   = (phase_q != lpws_pkg::PH_IDLE);
		result.frame_done = (phase_q == lpws_pkg::PH_LATCH) && ends;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpws_pkg::PH_IDLE;
			shift_q <= '0;
			bits_q  <= '0;
			tick_q  <= '0;
			last_q  <= 1'b0;
			zone_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
			tick_q  <= tick_d;
			last_q  <= last_d;
			zone_q  <= zone_d;
		end
	end

endmodule

>>> tb/sv/led_pulse_width_serializer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the LED pulse-width serializer unit.
module led_pulse_width_serializer_unit_tb;

	localparam logic [lpws_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int FIRST_SHORT_ROW = 4;
	localparam int RANDOM_TICKS    = 90;
	localparam int PRESSURE_AT     = 400;
	localparam int PRESSURE_CYCLES = 150;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_TWO_OF_THREE,
		RX_TRICKLE
	} stall_mode_t;

	typedef struct {
		lpws_pkg::in_item_t  stim;
		int unsigned         reps;
		bit                  typed;
		lpws_pkg::out_item_t want;
	} dir_row_t;

	// Rows before FIRST_SHORT_ROW run at reset timing, the rest with every length at 1.
	dir_row_t dir_rows [9] = '{
		'{{1'b0, 8'h00, 2'd0, 1'b0}, 1,  1'b1, {4'b0000, 1'b0, 1'b0, 1'b0}},
		'{{1'b0, 8'hFF, 2'd3, 1'b1}, 1,  1'b1, {4'b0000, 1'b0, 1'b0, 1'b0}},
		'{{1'b1, 8'hFF, 2'd3, 1'b1}, 1,  1'b1, {4'b0000, 1'b1, 1'b0, 1'b0}},
		'{{1'b1, 8'h00, 2'd0, 1'b1}, 1,  1'b1, {4'b1000, 1'b0, 1'b1, 1'b0}},
		'{{1'b1, 8'hA5, 2'd1, 1'b0}, 1,  1'b1, {4'b0000, 1'b1, 1'b0, 1'b0}},
		'{{1'b1, 8'h5A, 2'd2, 1'b1}, 16, 1'b0, '0},
		'{{1'b0, 8'h00, 2'd0, 1'b0}, 17, 1'b0, '0},
		'{{1'b1, 8'h3C, 2'd0, 1'b0}, 1,  1'b0, '0},
		'{{1'b0, 8'hC3, 2'd1, 1'b1}, 17, 1'b0, '0}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [lpws_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lpws_pkg::CFG_DATA_W-1:0] cfg_data;

	lpws_in_if  in_ch ();
	lpws_out_if out_ch ();

	led_pulse_width_serializer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the encoder state and timing registers.
	lpws_pkg::timing_cfg_t          timing;
	lpws_pkg::phase_t               line_phase;
	logic [lpws_pkg::BYTE_W-1:0]    shift_reg;
	logic [lpws_pkg::BIT_CNT_W-1:0] bits_left;
	logic [lpws_pkg::TICK_W-1:0]    ticks_left;
	logic                           last_pending;
	logic [lpws_pkg::ZONE_W-1:0]    active_zone;

	lpws_pkg::out_item_t expected_ticks [$];
	int unsigned         mismatch_count;
	int unsigned         results_seen;
	int unsigned         burst_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("** led_pulse_width_serializer_unit: FAILED **");
		$finish;
	end

	function automatic logic [lpws_pkg::TICK_W-1:0] high_len();
		return lpws_pkg::TICK_W'(shift_reg[lpws_pkg::BYTE_W-1] ?
			timing.one_high : timing.zero_high);
	endfunction

	function automatic logic [lpws_pkg::TICK_W-1:0] low_len();
		return lpws_pkg::TICK_W'(shift_reg[lpws_pkg::BYTE_W-1] ?
			timing.one_low : timing.zero_low);
	endfunction

	function automatic void load_byte(lpws_pkg::in_item_t t);
		shift_reg    = t.color_byte;
		active_zone  = t.zone_select;
		last_pending = t.frame_end;
		bits_left    = lpws_pkg::LAST_BIT_IDX;
		line_phase   = lpws_pkg::PH_HIGH;
		ticks_left   = high_len();
	endfunction

	// Outputs reflect the state at the start of the tick; the state advances afterwards.
	function automatic lpws_pkg::out_item_t predict_tick(lpws_pkg::in_item_t t);
		lpws_pkg::out_item_t r;
		logic                ends;
		r = '0;
		r.busy_res = (line_phase != lpws_pkg::PH_IDLE);
		ends = (ticks_left <= 1);
		if (line_phase == lpws_pkg::PH_HIGH && int'(active_zone) < lpws_pkg::ZONE_COUNT) begin
			r.line_levels = lpws_pkg::LINE_W'(1) << active_zone;
		end
		case (line_phase)
			lpws_pkg::PH_IDLE: begin
				if (t.offer_byte) begin
					load_byte(t);
					r.byte_taken = 1'b1;
				end
			end
			lpws_pkg::PH_HIGH: begin
				if (ends) begin
					line_phase = lpws_pkg::PH_LOW;
					ticks_left = low_len();
				end else begin
					ticks_left--;
				end
			end
			lpws_pkg::PH_LOW: begin
				if (!ends) begin
					ticks_left--;
				end else if (bits_left != 0) begin
					bits_left--;
					shift_reg  = shift_reg << 1;
					line_phase = lpws_pkg::PH_HIGH;
					ticks_left = high_len();
				end else if (last_pending) begin
					last_pending = 1'b0;
					line_phase   = lpws_pkg::PH_LATCH;
					ticks_left   = timing.latch;
				end else if (t.offer_byte) begin
					load_byte(t);
					r.byte_taken = 1'b1;
				end else begin
					line_phase = lpws_pkg::PH_IDLE;
					ticks_left = '0;
				end
			end
			default: begin
				if (ends) begin
					r.frame_done = 1'b1;
					line_phase   = lpws_pkg::PH_IDLE;
					ticks_left   = '0;
				end else begin
					ticks_left--;
				end
			end
		endcase
		return r;
	endfunction

	function automatic void check_tick(lpws_pkg::out_item_t got);
		lpws_pkg::out_item_t want;
		if (expected_ticks.size() == 0) begin
			$error("result transaction with nothing expected: %h", got);
			mismatch_count++;
			return;
		end
		want = expected_ticks.pop_front();
		if (got.line_levels !== want.line_levels) begin
			$error("line_levels: expected %h, got %h", want.line_levels, got.line_levels);
			mismatch_count++;
		end
		if (got.byte_taken !== want.byte_taken) begin
			$error("byte_taken: expected %b, got %b", want.byte_taken, got.byte_taken);
			mismatch_count++;
		end
		if (got.busy_res !== want.busy_res) begin
			$error("busy_res: expected %b, got %b", want.busy_res, got.busy_res);
			mismatch_count++;
		end
		if (got.frame_done !== want.frame_done) begin
			$error("frame_done: expected %b, got %b", want.frame_done, got.frame_done);
			mismatch_count++;
		end
	endfunction

	function automatic lpws_pkg::in_item_t random_tick();
		logic [31:0] rnd;
		rnd = $urandom;
		return rnd[$bits(lpws_pkg::in_item_t)-1:0];
	endfunction

	// A 10-bit length with junk in the unused upper bits of the data word.
	function automatic logic [lpws_pkg::CFG_DATA_W-1:0] pulse_word(int unsigned lo,
			int unsigned hi);
		logic [lpws_pkg::CFG_DATA_W-1:0] w;
		logic [31:0]                     rnd;
		rnd = $urandom;
		w = lpws_pkg::CFG_DATA_W'($urandom_range(hi, lo));
		w[lpws_pkg::CFG_DATA_W-1:lpws_pkg::PULSE_W] =
			rnd[lpws_pkg::CFG_DATA_W-lpws_pkg::PULSE_W-1:0];
		return w;
	endfunction

	task automatic write_reg(logic [lpws_pkg::CFG_IDX_W-1:0] idx,
			logic [lpws_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lpws_pkg::REG_ZERO_HIGH: timing.zero_high = data[lpws_pkg::PULSE_W-1:0];
			lpws_pkg::REG_ZERO_LOW:  timing.zero_low  = data[lpws_pkg::PULSE_W-1:0];
			lpws_pkg::REG_ONE_HIGH:  timing.one_high  = data[lpws_pkg::PULSE_W-1:0];
			lpws_pkg::REG_ONE_LOW:   timing.one_low   = data[lpws_pkg::PULSE_W-1:0];
			lpws_pkg::REG_LATCH:     timing.latch     = data[lpws_pkg::TICK_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_timing(logic [lpws_pkg::CFG_DATA_W-1:0] zh,
			logic [lpws_pkg::CFG_DATA_W-1:0] zl,
			logic [lpws_pkg::CFG_DATA_W-1:0] oh, logic [lpws_pkg::CFG_DATA_W-1:0] ol,
			logic [lpws_pkg::CFG_DATA_W-1:0] lt);
		write_reg(lpws_pkg::REG_ZERO_HIGH, zh);
		write_reg(lpws_pkg::REG_ZERO_LOW, zl);
		write_reg(lpws_pkg::REG_ONE_HIGH, oh);
		write_reg(lpws_pkg::REG_ONE_LOW, ol);
		write_reg(lpws_pkg::REG_LATCH, lt);
	endtask

	// The sender works in bursts; a gap of idle cycles may open before each burst.
	task automatic send_tick(input lpws_pkg::in_item_t t, output logic taken,
			input bit use_want = 1'b0, input lpws_pkg::out_item_t want = '0);
		lpws_pkg::out_item_t r;
		int unsigned         gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(32, 1);
			gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(6, 1);
			if (gap != 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid       <= 1'b1;
		in_ch.offer_byte  <= t.offer_byte;
		in_ch.color_byte  <= t.color_byte;
		in_ch.zone_select <= t.zone_select;
		in_ch.frame_end   <= t.frame_end;
		do @(posedge clk); while (!in_ch.ready);
		r = predict_tick(t);
		expected_ticks.push_back(use_want ? want : r);
		taken = r.byte_taken;
	endtask

	// Feeds ticks without offers until the line has finished its frame.
	task automatic drain_line();
		lpws_pkg::in_item_t t;
		logic               taken;
		while (line_phase != lpws_pkg::PH_IDLE) begin
			t = random_tick();
			t.offer_byte = 1'b0;
			send_tick(t, taken);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_ticks.size() != 0) @(posedge clk);
	endtask

	// Mostly whole frames whose bytes are held until taken, mixed with stray offers
	// and dropped frames.
	task automatic random_ticks(int unsigned n);
		lpws_pkg::in_item_t t;
		lpws_pkg::in_item_t held;
		logic               taken;
		bit                 holding;
		int unsigned        frame_left;
		int unsigned        k;
		holding = 1'b0;
		frame_left = 0;
		held = '0;
		for (k = 0; k < n; k++) begin
			if (!holding && frame_left == 0 && $urandom_range(3, 0) != 0) begin
				frame_left = $urandom_range(6, 1);
			end
			if (!holding && frame_left != 0 && $urandom_range(9, 0) != 0) begin
				held = random_tick();
				held.offer_byte = 1'b1;
				held.frame_end = (frame_left == 1);
				holding = 1'b1;
			end
			if (holding) begin
				t = held;
			end else begin
				t = random_tick();
				if ($urandom_range(3, 0) != 0) begin
					t.offer_byte = 1'b0;
				end
				if ($urandom_range(15, 0) == 0) begin
					frame_left = 0;
				end
			end
			send_tick(t, taken);
			if (holding && taken) begin
				holding = 1'b0;
				frame_left--;
			end
		end
	endtask

	initial begin
		lpws_pkg::in_item_t t;
		logic               taken;
		int unsigned        i;
		int unsigned        r;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = lpws_pkg::REG_ZERO_HIGH;
		cfg_data          = '0;
		in_ch.valid       = 1'b0;
		in_ch.offer_byte  = 1'b0;
		in_ch.color_byte  = '0;
		in_ch.zone_select = '0;
		in_ch.frame_end   = 1'b0;
		timing            = {lpws_pkg::ZERO_HIGH_RST, lpws_pkg::ZERO_LOW_RST,
			lpws_pkg::ONE_HIGH_RST, lpws_pkg::ONE_LOW_RST, lpws_pkg::LATCH_RST};
		line_phase        = lpws_pkg::PH_IDLE;
		shift_reg         = '0;
		bits_left         = '0;
		ticks_left        = '0;
		last_pending      = 1'b0;
		active_zone       = '0;
		mismatch_count    = 0;
		burst_left        = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < $size(dir_rows); i++) begin
			if (i == FIRST_SHORT_ROW) begin
				// Short lengths take effect from the next phase of the running frame.
				wait_idle();
				set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
				drain_line();
				wait_idle();
			end
			repeat (dir_rows[i].reps) begin
				send_tick(dir_rows[i].stim, taken, dir_rows[i].typed, dir_rows[i].want);
			end
		end
		drain_line();
		wait_idle();

		// Writes to an unmapped index must leave the timing alone.
		write_reg(REG_UNUSED, '1);
		// A length of zero behaves as one tick.
		set_timing('0, '0, '0, '0, '0);
		random_ticks(RANDOM_TICKS);
		drain_line();
		wait_idle();

		for (r = 0; r < 3; r++) begin
			set_timing(pulse_word(1, 2 + 3 * r), pulse_word(1, 2 + 3 * r),
				pulse_word(1, 2 + 3 * r), pulse_word(1, 2 + 3 * r),
				lpws_pkg::CFG_DATA_W'($urandom_range(2 + 14 * r, 1)));
			random_ticks(RANDOM_TICKS);
			drain_line();
			wait_idle();
		end

		// Different lengths in every register: one single-byte frame.
		set_timing(16'd2, 16'd6, 16'd9, 16'd3, 16'd30);
		t = random_tick();
		t.offer_byte = 1'b1;
		t.color_byte = 8'h96;
		t.frame_end = 1'b1;
		do send_tick(t, taken); while (!taken);
		drain_line();
		wait_idle();

		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("** led_pulse_width_serializer_unit: PASSED **");
		end else begin
			$display("** led_pulse_width_serializer_unit: FAILED **");
		end
		$finish;
	end

	// Result side: checks every transaction and stalls on a changing pattern, with one
	// long hold-off that backs the block up into its input.
	initial begin
		lpws_pkg::out_item_t got;
		stall_mode_t         mode;
		int unsigned         mode_left;
		int unsigned         hold;
		int unsigned         cyc;
		out_ch.ready = 1'b0;
		results_seen = 0;
		mode = RX_OPEN;
		mode_left = 0;
		hold = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
				got.line_levels = out_ch.line_levels;
				got.byte_taken  = out_ch.byte_taken;
				got.busy_res    = out_ch.busy_res;
				got.frame_done  = out_ch.frame_done;
				check_tick(got);
				results_seen++;
				if (results_seen == PRESSURE_AT) begin
					hold = PRESSURE_CYCLES;
				end
			end
			@(negedge clk);
			cyc++;
			if (hold != 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = stall_mode_t'($urandom_range(3, 0));
					mode_left = $urandom_range(80, 10);
				end
				mode_left--;
				case (mode)
					RX_OPEN:         out_ch.ready <= 1'b1;
					RX_COIN:         out_ch.ready <= 1'($urandom_range(1, 0));
					RX_TWO_OF_THREE: out_ch.ready <= (cyc % 3 != 0);
					default:         out_ch.ready <= ($urandom_range(3, 0) == 0);
				endcase
			end
		end
	end

endmodule
